// ===== rtl/sdl_pkg.sv =====
// Package with shared widths, register indexes and result type for the dip locator.
`default_nettype none
package sdl_pkg;
    localparam int ANGLE_W = 12;
    localparam int DIST_W  = 10;
    localparam int TOL_W   = 8;
    localparam int RUN_W   = 6;
    localparam int MISM_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_TOL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MINRUN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MISM    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BEST    = 3'd4;

    localparam logic [DIST_W-1:0] MIN_SEED = 10'd450;

    typedef struct packed {
        logic                overflow;
        logic                angle_valid;
        logic [DIST_W-1:0]   dip_distance;
        logic [ANGLE_W-1:0]  dip_angle;
        logic                dip_found;
    } t_result;
endpackage
`default_nettype wire

// ===== rtl/scan_dip_locator_core.sv =====
// Top level of the scan dip locator: point store, run search sequencer and result register.
//
// Points enter on the s_axis channel: tdata carries scan_angle then scan_distance, tuser
// carries last_point. While the block is idle a point is accepted every cycle; it is
// written to the store while there is room, else dropped and flagged as overflow. A point
// marked last starts the analysis, which walks the distance memory through a sequencer
// with one registered read port. For each candidate run start it scans forward for
// matches, waiting for each read before the next. If the run is long enough it reads it
// again for its minimum, then up to FLANK_POINTS points on each side, then the angle at
// the middle of the run when it becomes the best dip. Each flank sum is compared with its
// count times the reference plus tolerance plus one, so no divide is needed. If no run
// start qualifies, ST_START goes straight to ST_OUT. No point is accepted while the
// analysis runs or while the result waits in the output register. When the receiver
// stalls, the result is held there; the block is ready in the cycle after it is taken.
// The result appears on m_axis: tdata carries dip_found, dip_angle, dip_distance,
// angle_valid and overflow from the lowest bit up. Configuration writes arrive on the
// cfg channel, which is always ready. Reset loads the register defaults, empties the
// store and clears the result register; the memories are not cleared.
`default_nettype none
module scan_dip_locator_core
    import sdl_pkg::*;
#(
    parameter int MAX_POINTS   = 32,
    parameter int FLANK_POINTS = 3
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire  [23:0]           s_axis_tdata,   // scan_angle[11:0], scan_distance[21:12]
    input  wire                   s_axis_tuser,   // last_point
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    output logic [31:0]           m_axis_tdata,   // dip_found, dip_angle, dip_distance,
                                                  // angle_valid, overflow
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = AW + 1;
    localparam int FW = $clog2(FLANK_POINTS + 1);
    localparam int SW = DIST_W + FW;
    localparam int PW = CW + 2;
    localparam int XW = DIST_W + FW + 2;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_START = 4'd1;
    localparam logic [3:0] ST_REF   = 4'd2;
    localparam logic [3:0] ST_SCAN  = 4'd3;
    localparam logic [3:0] ST_MIN   = 4'd4;
    localparam logic [3:0] ST_AFT   = 4'd5;
    localparam logic [3:0] ST_BEF   = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_DEC   = 4'd8;
    localparam logic [3:0] ST_ANG   = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;
    localparam logic [3:0] ST_WAIT  = 4'd11;

    logic [ANGLE_W-1:0] r_angle_mem [MAX_POINTS];
    logic [DIST_W-1:0]  r_dist_mem  [MAX_POINTS];
    logic [ANGLE_W-1:0] r_angle_rd;
    logic [DIST_W-1:0]  r_dist_rd;

    logic [TOL_W-1:0]  r_tol;
    logic [RUN_W-1:0]  r_minrun;
    logic [MISM_W-1:0] r_mism_max;
    logic [DIST_W-1:0] r_near;
    logic [DIST_W-1:0] r_init_best;

    logic [3:0]         r_state, n_state;
    logic [CW-1:0]      r_count;
    logic               r_dropped;
    logic [CW-1:0]      r_start;
    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      r_len;
    logic [MISM_W-1:0]  r_mism;
    logic [DIST_W-1:0]  r_ref;
    logic [DIST_W-1:0]  r_min;
    logic [SW-1:0]      r_sum;
    logic [FW-1:0]      r_cnt;
    logic               r_hi_a;
    logic               r_hi_b;
    logic               r_rd_pend;
    logic [DIST_W-1:0]  r_best;
    logic [ANGLE_W-1:0] r_best_ang;
    logic               r_two;
    logic               r_found;
    logic               r_valid;
    logic               r_div_aft;
    t_result            r_res;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [DIST_W:0]    ref_tol;
    logic [DIST_W-1:0]  diff;
    logic [PW-1:0]      run_end;
    logic               in_acc;
    logic [XW-1:0]      flank_need;
    logic               flank_high;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign ref_tol = {1'b0, r_ref} + {3'b0, r_tol};
    assign diff = (r_dist_rd > r_ref) ? (r_dist_rd - r_ref) : (r_ref - r_dist_rd);
    assign wr_en = in_acc && (r_count < CW'(MAX_POINTS));
    assign wr_addr = r_count[AW-1:0];
    assign run_end = PW'(r_start) + PW'(r_minrun);
    assign flank_need = XW'(r_cnt) * (XW'(ref_tol) + XW'(1));
    assign flank_high = (r_cnt != '0) && (XW'(r_sum) >= flank_need);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_angle_mem[wr_addr] <= s_axis_tdata[ANGLE_W-1:0];
            r_dist_mem[wr_addr]  <= s_axis_tdata[ANGLE_W+DIST_W-1:ANGLE_W];
        end
        if (rd_en) begin
            r_angle_rd <= r_angle_mem[rd_addr];
            r_dist_rd  <= r_dist_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_W'(5);
            r_minrun <= RUN_W'(4);
            r_mism_max <= MISM_W'(1);
            r_near <= DIST_W'(100);
            r_init_best <= DIST_W'(450);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TOL:    r_tol <= i_cfg_data[TOL_W-1:0];
                REG_MINRUN: r_minrun <= i_cfg_data[RUN_W-1:0];
                REG_MISM:   r_mism_max <= i_cfg_data[MISM_W-1:0];
                REG_NEAR:   r_near <= i_cfg_data;
                REG_BEST:   r_init_best <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Read address per state; data arrives in the next cycle, with r_rd_pend set.
    always_comb begin
        rd_en = 1'b0;
        rd_addr = r_idx[AW-1:0];
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (in_acc && s_axis_tuser) n_state = ST_START;
            ST_START: begin
                if (PW'(r_start) + PW'(r_minrun) < PW'(r_count) + PW'(r_minrun) &&
                    run_end < PW'(r_count)) begin
                    rd_en = 1'b1;
                    rd_addr = r_start[AW-1:0];
                    n_state = ST_REF;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_REF:   n_state = ST_SCAN;
            ST_SCAN:  begin
                if (!r_rd_pend && r_idx < r_count) rd_en = 1'b1;
            end
            ST_MIN: begin
                if (!r_rd_pend) rd_en = 1'b1;
            end
            ST_AFT: begin
                if (!r_rd_pend && r_idx < r_count && r_cnt != FW'(FLANK_POINTS))
                    rd_en = 1'b1;
            end
            ST_BEF: begin
                if (!r_rd_pend && r_idx != '1 && r_cnt != FW'(FLANK_POINTS))
                    rd_en = 1'b1;
            end
            ST_ANG:   if (!r_rd_pend) rd_en = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_dropped <= 1'b0;
            r_rd_pend <= 1'b0;
            r_res <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            r_rd_pend <= rd_en;
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (wr_en) r_count <= r_count + CW'(1);
                        else r_dropped <= 1'b1;
                        if (s_axis_tuser) begin
                            r_state <= ST_START;
                            r_start <= '0;
                            r_best <= r_init_best;
                            r_best_ang <= '0;
                            r_two <= 1'b0;
                            r_found <= 1'b0;
                            r_valid <= 1'b0;
                        end
                    end
                end
                ST_START: begin
                    r_state <= n_state;
                    r_idx <= r_start + CW'(1);
                    r_len <= CW'(1);
                    r_mism <= '0;
                end
                ST_REF: begin
                    r_ref <= r_dist_rd;
                    r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (r_rd_pend) begin
                        if ({1'b0, diff} <= {3'b0, r_tol}) begin
                            r_len <= r_len + CW'(1);
                            r_idx <= r_idx + CW'(1);
                        end else if (r_mism < r_mism_max) begin
                            r_mism <= r_mism + MISM_W'(1);
                            r_idx <= r_idx + CW'(1);
                        end else begin
                            r_idx <= r_count;
                        end
                    end else if (!rd_en) begin
                        if (PW'(r_len) < PW'(r_minrun)) begin
                            r_start <= r_start + CW'(1);
                            r_state <= ST_START;
                        end else begin
                            r_idx <= r_start;
                            r_min <= MIN_SEED;
                            r_state <= ST_MIN;
                        end
                    end
                end
                ST_MIN: begin
                    if (r_rd_pend) begin
                        if (r_dist_rd < r_min) r_min <= r_dist_rd;
                        if (r_idx + CW'(1) == r_start + r_len) begin
                            r_idx <= r_start + r_len;
                            r_sum <= '0;
                            r_cnt <= '0;
                            r_state <= ST_AFT;
                        end else begin
                            r_idx <= r_idx + CW'(1);
                        end
                    end
                end
                ST_AFT: begin
                    if (r_rd_pend) begin
                        r_sum <= r_sum + SW'(r_dist_rd);
                        r_cnt <= r_cnt + FW'(1);
                        r_idx <= r_idx + CW'(1);
                    end else if (r_idx >= r_count ||
                                 r_cnt == FW'(FLANK_POINTS)) begin
                        r_div_aft <= 1'b1;
                        r_state <= ST_DIV;
                    end
                end
                ST_BEF: begin
                    if (r_rd_pend) begin
                        r_sum <= r_sum + SW'(r_dist_rd);
                        r_cnt <= r_cnt + FW'(1);
                        r_idx <= r_idx - CW'(1);
                    end else if (r_idx == '1 || r_cnt == FW'(FLANK_POINTS)) begin
                        r_div_aft <= 1'b0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_div_aft) begin
                        r_hi_a <= flank_high;
                        r_idx <= r_start - CW'(1);
                        r_sum <= '0;
                        r_cnt <= '0;
                        r_state <= ST_BEF;
                    end else begin
                        r_hi_b <= flank_high;
                        r_state <= ST_DEC;
                    end
                end
                ST_DEC: begin
                    r_state <= ST_START;
                    r_start <= r_start + r_len + CW'(1);
                    if (r_min < r_near) begin
                        if (r_hi_a && r_hi_b) begin
                            r_found <= 1'b1;
                            r_two <= 1'b1;
                            if (!r_two || r_min < r_best) begin
                                r_best <= r_min;
                                r_valid <= 1'b1;
                            end
                        end else if ((r_hi_a || r_hi_b) && !r_two) begin
                            r_found <= 1'b1;
                            if (r_min < r_best) begin
                                r_best <= r_min;
                                r_valid <= 1'b1;
                            end
                        end
                    end
                    if ((r_min < r_near) && (r_hi_a || r_hi_b) &&
                        (((r_hi_a && r_hi_b) && (!r_two || r_min < r_best)) ||
                         (!(r_hi_a && r_hi_b) && !r_two && r_min < r_best))) begin
                        r_idx <= r_start + (r_len >> 1);
                        r_state <= ST_ANG;
                    end
                end
                ST_ANG: begin
                    if (r_rd_pend) begin
                        r_best_ang <= r_angle_rd;
                        r_state <= ST_START;
                    end
                end
                ST_OUT: begin
                    r_res.dip_found <= r_found;
                    r_res.dip_angle <= r_valid ? r_best_ang : '0;
                    r_res.dip_distance <= r_best;
                    r_res.angle_valid <= r_valid;
                    r_res.overflow <= r_dropped;
                    m_axis_tvalid <= 1'b1;
                    r_count <= '0;
                    r_dropped <= 1'b0;
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (m_axis_tready) begin
                        m_axis_tvalid <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tdata = {{(32 - $bits(t_result)){1'b0}}, r_res};

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid) else $error("input ready while result pending");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS)) else $error("point count beyond store depth");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
endmodule
`default_nettype wire
